[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bsc_pkg.sv]
package bsc_pkg;

   // Operation field
   localparam int OP_BITS = 3;
   typedef logic [OP_BITS-1:0] op_type;

   localparam op_type OP_SET       = 3'd0;
   localparam op_type OP_CLEAR     = 3'd1;
   localparam op_type OP_TEST      = 3'd2;
   localparam op_type OP_FIND      = 3'd3;
   localparam op_type OP_CLEAR_ALL = 3'd4;

endpackage

[sv/bsc_ram.sv]
// Single-port-write, single-port-read word store, registered read data.
module bsc_ram #(
   parameter int ADDR_BITS = 11,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bsc_ffs.sv]
// Lowest set bit of a word: isolate it, then encode the one-hot result.
module bsc_ffs #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]         word,
   output logic                         any,
   output logic [$clog2(WORD_BITS)-1:0] pos
);

   localparam int SEL_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] lowest;

   // Two's complement trick leaves only the lowest one
   assign lowest = word & (~word + {{(WORD_BITS-1){1'b0}}, 1'b1});
   assign any    = |word;

   // One-hot to binary: each output bit ORs the positions that carry it
   always_comb begin
      pos = '0;
      for (int j = 0; j < SEL_BITS; j++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (((i >> j) & 1) == 1) begin
               pos[j] = pos[j] | lowest[i];
            end
         end
      end
   end

endmodule

[sv/bitmap_set_clear_find_next.sv]
// Bit set of 2**INDEX_BITS bits held in a word store of WORD_BITS-bit words.
// Input channel req_*: operation (set, clear, test, find next set at or after
// bit_index, clear all) and bit_index. One transaction is taken at a time;
// req_stall is high while a transaction is being worked on.
// Result channel rsp_*: one transaction per request with the prior value of
// the addressed bit, a found flag and index for find next, and the count of
// set bits after the request. An output register holds the result, so a new
// request can be taken while the receiver stalls; the block waits only if
// its next result is ready and the register is still full.
// Set, clear and test: the word read is issued at accept, then modified and
// written back in the next cycle. Find next reads the start word and then
// each further word in turn, up to the last word of the store. Clear all
// makes one write per word. Set, clear and test are taken one at a time, as
// the read-then-write of the store ends before the idle state takes the next
// request. After reset the store is zeroed with one write to each of its
// 2**INDEX_BITS/WORD_BITS words (2048 at the defaults); req_stall stays high
// until it is done.
module bitmap_set_clear_find_next #(
   parameter int INDEX_BITS = 16,
   parameter int WORD_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_operation,
   input  logic [INDEX_BITS-1:0] req_bit_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_prior_value,
   output logic                  rsp_found,
   output logic [INDEX_BITS-1:0] rsp_found_index,
   output logic [INDEX_BITS:0]   rsp_set_count
);

   `include "assert_macros.svh"

   localparam int SEL_BITS  = $clog2(WORD_BITS);
   localparam int ADDR_BITS = INDEX_BITS - SEL_BITS;
   localparam int CNT_BITS  = INDEX_BITS + 1;
   localparam logic [CNT_BITS-1:0] NUM_BITS = {1'b1, {INDEX_BITS{1'b0}}};

   // State codes
   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_FIND = 3'd3;
   localparam logic [2:0] ST_WIPE = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]            state_ff, state_in;
   bsc_pkg::op_type       op_ff, op_in;
   logic [INDEX_BITS-1:0] bit_ff, bit_in;
   logic [ADDR_BITS-1:0]  word_ff, word_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  prior_ff, prior_in;
   logic                  found_ff, found_in;
   logic [INDEX_BITS-1:0] found_idx_ff, found_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_prior_ff;
   logic                  rsp_found_ff;
   logic [INDEX_BITS-1:0] rsp_found_index_ff;
   logic [CNT_BITS-1:0]   rsp_set_count_ff;

   logic                  wr_en, rd_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data, rd_data;

   logic [SEL_BITS-1:0]   bit_sel;
   logic                  read_bit;
   logic [WORD_BITS-1:0]  bit_mask, start_mask, scan_word;
   logic                  scan_any;
   logic [SEL_BITS-1:0]   scan_pos;
   logic                  word_last, out_free, load_rsp;
   logic                  fin, fin_prior, fin_found;
   logic [INDEX_BITS-1:0] fin_index;

   // Word store
   bsc_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Bit selection inside the word just read
   assign bit_sel    = bit_ff[SEL_BITS-1:0];
   assign read_bit   = rd_data[bit_sel];
   assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
   assign start_mask = {WORD_BITS{1'b1}} << bit_sel;
   assign scan_word  = (state_ff == ST_READ) ? (rd_data & start_mask) : rd_data;
   assign word_last  = &word_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Lowest set bit of the word under scan
   bsc_ffs #(
      .WORD_BITS (WORD_BITS)
   ) u_ffs (
      .word (scan_word),
      .any  (scan_any),
      .pos  (scan_pos)
   );

   // Sequencer. A write-back only happens in the cycle after the read of the
   // same word and the next read comes later, so no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bit_in       = bit_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      prior_in     = prior_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = '0;
      fin          = 1'b0;
      fin_prior    = prior_ff;
      fin_found    = found_ff;
      fin_index    = found_idx_ff;

      unique case (state_ff) inside
         ST_INIT: begin
            wr_en = 1'b1;
            if (word_last) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end else begin
               word_in = word_ff + ADDR_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               bit_in   = req_bit_index;
               word_in  = req_bit_index[INDEX_BITS-1:SEL_BITS];
               rd_en    = 1'b1;
               rd_addr  = req_bit_index[INDEX_BITS-1:SEL_BITS];
               state_in = ST_READ;
            end
         end
         ST_READ, ST_FIND: begin
            if (state_ff == ST_READ) begin
               prior_in  = read_bit;
               fin_prior = read_bit;
            end
            fin_found = 1'b0;
            fin_index = '0;
            if (state_ff == ST_READ && op_ff == bsc_pkg::OP_SET) begin
               if (!read_bit) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data | bit_mask;
                  count_in = count_ff + CNT_BITS'(1);
               end
               fin = 1'b1;
            end else if (state_ff == ST_READ && op_ff == bsc_pkg::OP_CLEAR) begin
               if (read_bit) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data & ~bit_mask;
                  count_in = count_ff - CNT_BITS'(1);
               end
               fin = 1'b1;
            end else if (state_ff == ST_READ && op_ff == bsc_pkg::OP_CLEAR_ALL) begin
               word_in  = '0;
               state_in = ST_WIPE;
            end else if (op_ff == bsc_pkg::OP_FIND) begin
               // Scan word by word from the start position
               if (scan_any) begin
                  fin       = 1'b1;
                  fin_found = 1'b1;
                  fin_index = {word_ff, scan_pos};
               end else if (word_last) begin
                  fin = 1'b1;
               end else begin
                  word_in  = word_ff + ADDR_BITS'(1);
                  rd_en    = 1'b1;
                  rd_addr  = word_ff + ADDR_BITS'(1);
                  state_in = ST_FIND;
               end
            end else begin
               // Test and unused codes change nothing
               fin = 1'b1;
            end
         end
         ST_WIPE: begin
            wr_en = 1'b1;
            if (word_last) begin
               count_in  = '0;
               fin       = 1'b1;
               fin_found = 1'b0;
               fin_index = '0;
            end else begin
               word_in = word_ff + ADDR_BITS'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            word_in  = '0;
         end
      endcase

      // Park the result if the output register is still occupied
      if (fin) begin
         prior_in     = fin_prior;
         found_in     = fin_found;
         found_idx_in = fin_index;
         state_in     = out_free ? ST_IDLE : ST_DONE;
      end
   end

   assign load_rsp     = (fin || state_ff == ST_DONE) && out_free;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         word_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction and pending result
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      bit_ff       <= bit_in;
      prior_ff     <= prior_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_prior_ff       <= fin_prior;
         rsp_found_ff       <= fin_found;
         rsp_found_index_ff <= fin_index;
         rsp_set_count_ff   <= count_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prior_value = rsp_prior_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_set_count   = rsp_set_count_ff;

   // Checks
   `ASSERT_IMPLIES(a_no_rw_collision, wr_en && rd_en, wr_addr != rd_addr,
      "store read and written at the same word in one cycle")
   `ASSERT_IMPLIES(a_found_after_start, load_rsp && fin_found, fin_index >= bit_ff,
      "find next reported a bit below the start position")
   `ASSERT_IMPLIES(a_found_needs_count, rsp_valid_ff && rsp_found_ff,
      rsp_set_count_ff != '0, "found a set bit while the count is zero")
   `ASSERT_NEXT(a_count_range, 1'b1, count_ff <= NUM_BITS,
      "set bit count exceeds the number of bits")

endmodule
